// File: design/hhp_pkg.sv
// hhp_pkg: types, character constants and the per-pass line machine step
// for the HTTP header section parser. No dependencies.
package hhp_pkg;

	localparam logic [7:0]  CH_CR       = 8'h0D;
	localparam logic [7:0]  CH_LF       = 8'h0A;
	localparam logic [7:0]  CH_COLON    = 8'h3A;
	localparam logic [15:0] LIMIT_RESET = 16'd8192;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
	localparam int          MAX_RESULTS = 3;

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_BLANK_END,
		PH_KEY,
		PH_PRE_VALUE,
		PH_VALUE,
		PH_VALUE_CR,
		PH_BAD_LINE
	} phase_t;

	typedef enum logic [2:0] {
		KIND_KEY,
		KIND_VALUE,
		KIND_HEND,
		KIND_OK,
		KIND_BAD,
		KIND_LARGE,
		KIND_ABORT
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] key_length;
		logic [15:0] value_length;
		logic        last;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic        bad_line_seen;
		logic [15:0] key_count;
		logic [15:0] value_count;
		logic [15:0] value_trimmed_count;
	} pstate_t;

	typedef struct packed {
		pstate_t st;
		logic    emit;
		result_t res;
		logic    again;   // same byte needs another pass
		logic    fin;     // section ended
	} pass_t;

	localparam pstate_t PSTATE_CLEAR = '{
		phase: PH_LINE_START, bad_line_seen: 1'b0,
		key_count: 16'd0, value_count: 16'd0, value_trimmed_count: 16'd0};

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= 8'h20) && (c <= 8'h7E);
	endfunction

	function automatic logic is_graph(input logic [7:0] c);
		return (c >= 8'h21) && (c <= 8'h7E);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// One pass of the line machine over byte c; at most one result per pass.
	function automatic pass_t hhp_pass(input pstate_t s, input logic [7:0] c);
		pass_t       r;
		logic [15:0] vc;
		vc = sat_inc(s.value_count);
		r = '0;
		r.st = s;
		r.res.kind = KIND_KEY;
		unique case (s.phase)
			PH_LINE_START: begin
				if (c == CH_CR || is_blank(c)) begin
					r.st.phase = PH_BLANK_END;
				end else if (c == CH_LF) begin
					r.fin = 1'b1;
					r.emit = 1'b1;
					r.res.kind = s.bad_line_seen ? KIND_BAD : KIND_OK;
				end else if (is_alnum(c)) begin
					r.st.key_count = 16'd1;
					r.emit = 1'b1;
					r.res.kind = KIND_KEY;
					r.res.out_byte = c;
					r.st.phase = PH_KEY;
				end else begin
					r.st.phase = PH_BAD_LINE;
				end
			end
			PH_BLANK_END: begin
				if (c == CH_LF) begin
					r.fin = 1'b1;
					r.emit = 1'b1;
					r.res.kind = s.bad_line_seen ? KIND_BAD : KIND_OK;
				end else if (!is_space(c)) begin
					r.st.phase = PH_BAD_LINE;
				end
			end
			PH_KEY: begin
				if (c == CH_COLON) begin
					r.st.phase = PH_PRE_VALUE;
				end else if (is_graph(c)) begin
					r.st.key_count = sat_inc(s.key_count);
					r.emit = 1'b1;
					r.res.kind = KIND_KEY;
					r.res.out_byte = c;
				end else begin
					r.st.phase = PH_BAD_LINE;
				end
			end
			PH_PRE_VALUE: begin
				if (!is_blank(c)) begin
					r.st.value_count = 16'd0;
					r.st.value_trimmed_count = 16'd0;
					r.st.phase = PH_VALUE;
					r.again = 1'b1;
				end
			end
			PH_VALUE: begin
				if (is_print(c)) begin
					r.st.value_count = vc;
					if (!is_space(c)) r.st.value_trimmed_count = vc;
					r.emit = 1'b1;
					r.res.kind = KIND_VALUE;
					r.res.out_byte = c;
				end else if (c == CH_CR) begin
					r.st.phase = PH_VALUE_CR;
				end else if (c == CH_LF) begin
					r.st.phase = PH_VALUE_CR;
					r.again = 1'b1;
				end else begin
					r.st.phase = PH_BAD_LINE;
				end
			end
			PH_VALUE_CR: begin
				if (c == CH_LF) begin
					r.emit = 1'b1;
					r.res.kind = KIND_HEND;
					r.res.key_length = s.key_count;
					r.res.value_length = s.value_trimmed_count;
					r.st.phase = PH_LINE_START;
				end else begin
					// lone CR stays in the value, then the byte is seen again
					r.st.value_count = vc;
					r.emit = 1'b1;
					r.res.kind = KIND_VALUE;
					r.res.out_byte = CH_CR;
					r.st.phase = PH_VALUE;
					r.again = 1'b1;
				end
			end
			default: begin
				if (c == CH_LF) begin
					r.st.bad_line_seen = 1'b1;
					r.st.phase = PH_LINE_START;
				end
			end
		endcase
		return r;
	endfunction

endpackage

// File: design/hhp_if.sv
// Channel interfaces for the header section parser: byte input and result output.
// Depends on hhp_pkg.
interface hhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;
	logic       link_lost;

	modport source (output valid, data_byte, restart, link_lost, input ready);
	modport sink (input valid, data_byte, restart, link_lost, output ready);
endinterface

interface hhp_result_if import hhp_pkg::*;;
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [7:0]  out_byte;
	logic [15:0] key_length;
	logic [15:0] value_length;
	logic        last;

	modport source (output valid, kind, out_byte, key_length, value_length, last,
		input ready);
	modport sink (input valid, kind, out_byte, key_length, value_length, last,
		output ready);
endinterface

// File: design/hhp_result_fifo.sv
// hhp_result_fifo: result queue taking up to three entries per cycle and
// giving one per cycle when popped. Depends on hhp_pkg.
module hhp_result_fifo import hhp_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        wr_count,
	input  result_t [MAX_RESULTS-1:0]         wr_data,
	input  logic                              pop,
	output result_t                           rd_data,
	output logic [$clog2(DEPTH+1)-1:0]        count
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	result_t            mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < wr_count) mem[wr_ptr_q + PTR_W'(i)] <= wr_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(wr_count) - CNT_W'(pop);
		end
	end

	assign rd_data = mem[rd_ptr_q];
	assign count   = count_q;
endmodule

// File: design/http_header_section_parser.sv
// http_header_section_parser: top level; byte input register, line machine
// and result queue. Depends on hhp_pkg, hhp_if, hhp_result_fifo.
//
//  port  | dir  | transaction payload
//  ------+------+---------------------------------------------------------
//  hdr   | sink | data_byte[7:0], restart, link_lost
//  evt   | src  | kind[2:0], out_byte[7:0], key_length[15:0], value_length[15:0], last
//  cfg   | in   | cfg_we, cfg_data[15:0] -> header_byte_limit
//
// One byte per cycle while hdr.ready is high: a byte is captured in the input
// register, then its zero to three results enter the queue together. The output
// side drains one result per cycle while evt.ready is high, so bytes that give two
// or more results slow the input once the queue fills. hdr.ready drops when the
// queue may lack room for the byte in flight plus one more. Reset empties both
// stages and sets the limit to 8192. RESULT_DEPTH is a power of two, at least 8.
module http_header_section_parser import hhp_pkg::*; #(
	parameter int RESULT_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	hhp_byte_if.sink     hdr,
	hhp_result_if.source evt,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_data
);
	localparam int CNT_W = $clog2(RESULT_DEPTH+1);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	logic        link_lost_s1;

	logic [15:0] limit_q;
	pstate_t     ps_q;
	logic        finished_q;
	logic [15:0] taken_q;

	pstate_t     cur_st, ps_d;
	logic        fin_cur, fin_d;
	logic [15:0] taken_cur, taken_d, taken_inc;
	pass_t       p1, p2, p3;
	logic        cand_v [4];
	result_t     cand_r [4];
	result_t [MAX_RESULTS-1:0] res;
	logic [1:0]  n_res;

	logic [CNT_W-1:0] q_count;
	result_t          q_head;
	logic             pop;

	assign hdr.ready = (q_count + (valid_s1 ? CNT_W'(MAX_RESULTS) : CNT_W'(0)))
		<= CNT_W'(RESULT_DEPTH - MAX_RESULTS);

	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			byte_s1      <= hdr.data_byte;
			restart_s1   <= hdr.restart;
			link_lost_s1 <= hdr.link_lost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			limit_q    <= LIMIT_RESET;
			ps_q       <= PSTATE_CLEAR;
			finished_q <= 1'b0;
			taken_q    <= '0;
		end else begin
			valid_s1 <= hdr.valid && hdr.ready;
			if (cfg_we) limit_q <= cfg_data;
			if (valid_s1) begin
				ps_q       <= ps_d;
				finished_q <= fin_d;
				taken_q    <= taken_d;
			end
		end
	end

	// All passes over the byte are evaluated side by side; the limit is
	// rechecked only after the first pass since the count is fixed by then.
	always_comb begin
		cur_st    = restart_s1 ? PSTATE_CLEAR : ps_q;
		fin_cur   = restart_s1 ? 1'b0 : finished_q;
		taken_cur = restart_s1 ? 16'd0 : taken_q;
		taken_inc = sat_inc(taken_cur);
		p1 = hhp_pass(cur_st, byte_s1);
		p2 = hhp_pass(p1.st, byte_s1);
		p3 = hhp_pass(p2.st, byte_s1);
		ps_d    = cur_st;
		fin_d   = fin_cur;
		taken_d = taken_cur;
		for (int i = 0; i < 4; i++) begin
			cand_v[i] = 1'b0;
			cand_r[i] = '0;
		end
		cand_r[0].kind = KIND_LARGE;
		cand_r[1].kind = KIND_LARGE;
		if (!fin_cur) begin
			if (taken_cur >= limit_q) begin
				cand_v[0] = 1'b1;
				fin_d     = 1'b1;
			end else if (link_lost_s1) begin
				cand_v[0]      = 1'b1;
				cand_r[0].kind = KIND_ABORT;
				fin_d          = 1'b1;
			end else begin
				taken_d   = taken_inc;
				ps_d      = p1.st;
				cand_v[0] = p1.emit;
				cand_r[0] = p1.res;
				if (p1.fin) begin
					fin_d = 1'b1;
				end else if (taken_inc >= limit_q) begin
					cand_v[1] = 1'b1;
					fin_d     = 1'b1;
				end else if (p1.again) begin
					ps_d      = p2.st;
					cand_v[2] = p2.emit;
					cand_r[2] = p2.res;
					if (p2.again) begin
						ps_d      = p3.st;
						cand_v[3] = p3.emit;
						cand_r[3] = p3.res;
					end
				end
			end
		end
		// pack the results in order, at most three
		res   = '0;
		n_res = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				res[n_res] = cand_r[i];
				n_res      = n_res + 2'd1;
			end
		end
		if (n_res != 2'd0) res[n_res - 2'd1].last = 1'b1;
		if (!valid_s1) n_res = 2'd0;
	end

	assign pop = evt.valid && evt.ready;

	hhp_result_fifo #(
		.DEPTH(RESULT_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_count (n_res),
		.wr_data  (res),
		.pop      (pop),
		.rd_data  (q_head),
		.count    (q_count)
	);

	assign evt.valid        = (q_count != '0);
	assign evt.kind         = q_head.kind;
	assign evt.out_byte     = q_head.out_byte;
	assign evt.key_length   = q_head.key_length;
	assign evt.value_length = q_head.value_length;
	assign evt.last         = q_head.last;
endmodule

// File: bench/http_header_section_parser_test.sv
// Self-checking testbench for http_header_section_parser: drives byte transactions,
// predicts the result stream in a scoreboard class and compares field by field.
// Depends on hhp_pkg, hhp_if and the parser RTL.
`timescale 1ns / 100ps

module http_header_section_parser_test;
	import hhp_pkg::*;

	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	// Tracks the line machine state and holds the results still owed by the DUT.
	class hdr_scoreboard;
		logic [15:0] byte_limit;
		phase_t      ph;
		logic [15:0] taken;
		bit          bad_seen;
		bit          finished;
		logic [15:0] key_cnt;
		logic [15:0] val_cnt;
		logic [15:0] val_trim;
		result_t     item_res[$];
		result_t     expected[$];
		int          errors;

		function new();
			byte_limit = LIMIT_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			ph = PH_LINE_START;
			taken = '0;
			bad_seen = 0;
			finished = 0;
			key_cnt = '0;
			val_cnt = '0;
			val_trim = '0;
		endfunction

		function void set_limit(logic [15:0] v);
			byte_limit = v;
		endfunction

		function logic [15:0] bump(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function bit blank_char(logic [7:0] c);
			return c == CH_SP || c == CH_TAB;
		endfunction

		function bit white_char(logic [7:0] c);
			return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function bit printable(logic [7:0] c);
			return c >= 8'h20 && c <= 8'h7E;
		endfunction

		function bit visible(logic [7:0] c);
			return c >= 8'h21 && c <= 8'h7E;
		endfunction

		function bit alnum_char(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function void add(kind_t k, logic [7:0] b, logic [15:0] kl, logic [15:0] vl);
			result_t r;
			if (item_res.size() >= MAX_RESULTS) return;
			r.kind = k;
			r.out_byte = b;
			r.key_length = kl;
			r.value_length = vl;
			r.last = 1'b0;
			item_res = {item_res, r};
		endfunction

		function void end_section(kind_t k);
			add(k, 8'd0, 16'd0, 16'd0);
			finished = 1;
		endfunction

		function void value_byte(logic [7:0] c);
			val_cnt = bump(val_cnt);
			if (!white_char(c)) val_trim = val_cnt;
			add(KIND_VALUE, c, 16'd0, 16'd0);
		endfunction

		// one pass over c; 1 means the same byte goes around again
		function bit step_once(logic [7:0] c);
			case (ph)
				PH_LINE_START: begin
					if (c == CH_CR || blank_char(c)) ph = PH_BLANK_END;
					else if (c == CH_LF) end_section(bad_seen ? KIND_BAD : KIND_OK);
					else if (alnum_char(c)) begin
						key_cnt = 16'd1;
						add(KIND_KEY, c, 16'd0, 16'd0);
						ph = PH_KEY;
					end else ph = PH_BAD_LINE;
				end
				PH_BLANK_END: begin
					if (c == CH_LF) end_section(bad_seen ? KIND_BAD : KIND_OK);
					else if (!white_char(c)) ph = PH_BAD_LINE;
				end
				PH_KEY: begin
					if (c == CH_COLON) ph = PH_PRE_VALUE;
					else if (visible(c)) begin
						key_cnt = bump(key_cnt);
						add(KIND_KEY, c, 16'd0, 16'd0);
					end else ph = PH_BAD_LINE;
				end
				PH_PRE_VALUE: begin
					if (!blank_char(c)) begin
						val_cnt = '0;
						val_trim = '0;
						ph = PH_VALUE;
						return 1;
					end
				end
				PH_VALUE: begin
					if (printable(c)) value_byte(c);
					else if (c == CH_CR) ph = PH_VALUE_CR;
					else if (c == CH_LF) begin
						ph = PH_VALUE_CR;
						return 1;
					end else ph = PH_BAD_LINE;
				end
				PH_VALUE_CR: begin
					if (c == CH_LF) begin
						add(KIND_HEND, 8'd0, key_cnt, val_trim);
						ph = PH_LINE_START;
						return 0;
					end
					// lone CR is kept as value data, then c is seen again
					value_byte(CH_CR);
					ph = PH_VALUE;
					return 1;
				end
				default: begin
					if (c == CH_LF) begin
						bad_seen = 1;
						ph = PH_LINE_START;
					end
				end
			endcase
			return 0;
		endfunction

		// returns 1 when the byte was not simply ignored
		function bit note_input(logic [7:0] c, bit rs, bit ll);
			bit again;
			int p;
			item_res.delete();
			if (rs) clear();
			if (finished) return 0;
			if (taken >= byte_limit) end_section(KIND_LARGE);
			else if (ll) end_section(KIND_ABORT);
			else begin
				taken = bump(taken);
				again = 1;
				for (p = 0; again && p < 4; p++) begin
					again = step_once(c);
					if (finished) break;
					if (taken >= byte_limit) begin
						end_section(KIND_LARGE);
						break;
					end
				end
			end
			if (item_res.size() > 0) item_res[item_res.size() - 1].last = 1'b1;
			foreach (item_res[i]) expected = {expected, item_res[i]};
			return 1;
		endfunction

		task report(string msg);
			$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected result kind %s", got.kind.name()));
				return;
			end
			want = expected.pop_front();
			if (got.kind != want.kind)
				report($sformatf("kind %s, expected %s", got.kind.name(), want.kind.name()));
			if (got.out_byte != want.out_byte)
				report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
			if (got.key_length != want.key_length)
				report($sformatf("key_length %0d, expected %0d", got.key_length,
					want.key_length));
			if (got.value_length != want.value_length)
				report($sformatf("value_length %0d, expected %0d", got.value_length,
					want.value_length));
			if (got.last != want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;
	int          src_idle;
	int          snk_idle;
	int          handled;
	hdr_scoreboard sb;

	hhp_byte_if   hdr_ch();
	hhp_result_if evt_ch();

	http_header_section_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr(hdr_ch),
		.evt(evt_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		evt_ch.ready = ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			got.kind = evt_ch.kind;
			got.out_byte = evt_ch.out_byte;
			got.key_length = evt_ch.key_length;
			got.value_length = evt_ch.value_length;
			got.last = evt_ch.last;
			sb.check_result(got);
		end
	end

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] c, input bit rs, input bit ll);
		while ($urandom_range(99) < src_idle) begin
			hdr_ch.valid = 1'b0;
			@(negedge clk);
		end
		hdr_ch.valid = 1'b1;
		hdr_ch.data_byte = c;
		hdr_ch.restart = rs;
		hdr_ch.link_lost = ll;
		@(posedge clk);
		while (!hdr_ch.ready) @(posedge clk);
		handled += sb.note_input(c, rs, ll);
		@(negedge clk);
	endtask

	task automatic drain();
		hdr_ch.valid = 1'b0;
		while (sb.expected.size() != 0) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		drain();
		// a byte with no result may still sit in the input register
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		sb.set_limit(v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [7:0] pick_alnum();
		int r;
		r = $urandom_range(61);
		if (r < 10) return 8'(8'h30 + r);
		if (r < 36) return 8'(8'h41 + r - 10);
		return 8'(8'h61 + r - 36);
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(1) ? CH_SP : CH_TAB;
	endfunction

	// mostly well-formed sections with random content, some noise and broken lines
	task automatic send_section();
		logic [7:0] sec[$];
		logic [7:0] c;
		int nhdr;
		bit rs_first;
		nhdr = $urandom_range(3);
		rs_first = ($urandom_range(9) != 0);
		for (int h = 0; h < nhdr; h++) begin
			if ($urandom_range(19) == 0) begin
				repeat ($urandom_range(1, 4)) sec = {sec, 8'($urandom_range(255))};
				sec = {sec, CH_LF};
				continue;
			end
			sec = {sec, pick_alnum()};
			repeat ($urandom_range(4)) begin
				do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_COLON);
				sec = {sec, c};
			end
			sec = {sec, CH_COLON};
			repeat ($urandom_range(2)) sec = {sec, pick_blank()};
			repeat ($urandom_range(5)) begin
				case ($urandom_range(19))
					0: sec = {sec, CH_CR};
					1: sec = {sec, 8'($urandom_range(255))};
					2, 3: sec = {sec, pick_blank()};
					default: sec = {sec, 8'($urandom_range(8'h20, 8'h7E))};
				endcase
			end
			if ($urandom_range(1)) sec = {sec, CH_CR};
			sec = {sec, CH_LF};
		end
		case ($urandom_range(3))
			0: sec = {sec, CH_CR};
			1: ;
			2: sec = {sec, CH_SP};
			default: begin
				sec = {sec, CH_TAB};
				sec = {sec, CH_CR};
			end
		endcase
		sec = {sec, CH_LF};
		foreach (sec[i])
			send_byte(sec[i], i == 0 && rs_first, $urandom_range(49) == 0);
	endtask

	task automatic run_random(input int target);
		handled = 0;
		while (handled < target) send_section();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		hdr_ch.valid = 1'b0;
		hdr_ch.data_byte = '0;
		hdr_ch.restart = 1'b0;
		hdr_ch.link_lost = 1'b0;
		evt_ch.ready = 1'b0;
		src_idle = 6;
		snk_idle = 67;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// header with lone CR in the value, trailing blank, LF-only line end
		send_byte("H", 1, 0);
		send_byte("o", 0, 0);
		send_byte(CH_COLON, 0, 0);
		send_byte(CH_SP, 0, 0);
		send_byte("a", 0, 0);
		send_byte(CH_CR, 0, 0);
		send_byte("b", 0, 0);
		send_byte(CH_SP, 0, 0);
		send_byte(CH_LF, 0, 0);
		// malformed line, then an empty line with a blank before its CR ends with bad request
		send_byte(8'hFF, 0, 0);
		send_byte(CH_LF, 0, 0);
		send_byte(CH_SP, 0, 0);
		send_byte(CH_CR, 0, 0);
		send_byte(CH_LF, 0, 0);
		send_byte("x", 0, 0);
		// link lost mid-line
		send_byte("Z", 1, 0);
		send_byte(8'h00, 0, 0);
		send_byte(8'hFF, 0, 1);
		send_byte(CH_LF, 1, 0);
		// leave a section open, then drop the limit below bytes taken
		send_byte("A", 1, 0);
		send_byte("b", 0, 0);
		write_limit(16'd1);
		send_byte("c", 0, 0);
		run_random(4);
		// limit hit while the byte still needs its second pass
		write_limit(16'd3);
		send_byte("K", 1, 0);
		send_byte(CH_COLON, 0, 0);
		send_byte("v", 0, 0);
		send_byte("x", 0, 0);
		write_limit(16'd8192);
		run_random(10);

		drain();
		src_idle = 67;
		snk_idle = 6;
		write_limit(16'd65535);
		run_random(8);
		drain();
		run_random(8);
		write_limit(16'd9);
		run_random(6);

		drain();
		src_idle = 0;
		snk_idle = 0;
		write_limit(16'd300);
		run_random(8);

		hdr_ch.valid = 1'b0;
		for (int n = 0; n < 4000 && sb.expected.size() != 0; n++) @(negedge clk);
		if (sb.expected.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected.size()));
		repeat (20) @(negedge clk);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
